[rtl/lpm_pkg.sv]
// package for the prefix map cache: opcodes, status codes, beat and entry types
// and the prefix mask helper; no dependencies
package lpm_pkg;

  localparam int unsigned LpmEntries = 16;
  localparam logic [5:0] MaxLength = 6'd32;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_LENGTH = 2'd1,
    ST_FULL       = 2'd2,
    ST_UNUSED     = 2'd3
  } status_e;

  // beat handed from cell to cell
  typedef struct packed {
    kind_e       op;
    logic [31:0] addr;
    logic [5:0]  len;
    logic [31:0] loc;
    logic [31:0] life;
    logic        flag;
  } tok_t;

  typedef struct packed {
    logic        v;
    logic [31:0] pfx;
    logic [5:0]  len;
    logic [31:0] loc;
    logic [31:0] life;
  } ent_t;

  function automatic logic [31:0] len_mask(input logic [5:0] len);
    logic [31:0] m;
    if (len == 6'd0) begin
      m = 32'h0;
    end else if (len >= MaxLength) begin
      m = 32'hFFFF_FFFF;
    end else begin
      m = ~(32'hFFFF_FFFF >> len);
    end
    return m;
  endfunction

endpackage

[rtl/lpm_prefix_map_cache_core.sv]
// the beat walks the chain one slot per cycle, registered in every cell, and the result strobe
// done_o rises as the beat leaves the last cell; the result is taken with that strobe
// one operation at a time: start is refused while busy and is taken again in the strobe cycle
// the receiver cannot stall; results are shown for one cycle under done_o
// reset clears every slot valid bit and the chain beats; slot contents are not reset
// depends on lpm_pkg and lpm_cell
module lpm_prefix_map_cache_core import lpm_pkg::*; #(
  parameter int unsigned ENTRIES = LpmEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] address_i,
  input  logic [5:0]  prefix_length_i,
  input  logic [31:0] locator_i,
  input  logic [31:0] lifetime_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic        hit_o,
  output logic [31:0] found_locator_o,
  output logic [31:0] found_lifetime_o,
  output logic [5:0]  found_length_o
);

  logic    tok_v [ENTRIES+1];
  tok_t    tok   [ENTRIES+1];
  ent_t    ent   [ENTRIES+1];
  logic    accept;
  logic    bad_len;
  logic    full;
  logic    busy_q, busy_d;
  status_e status_q, status_d;
  kind_e   kind;
  tok_t    tok_in;

  assign kind    = kind_e'(kind_i);
  assign accept  = start_i && !busy_o;
  assign bad_len = prefix_length_i > MaxLength;
  assign full    = ent[ENTRIES-1].v;
  assign ent[ENTRIES] = '0;

  always_comb begin
    status_d     = ST_OK;
    tok_in.op    = KIND_NONE;
    tok_in.addr  = address_i;
    tok_in.len   = 6'd0;
    tok_in.loc   = 32'h0;
    tok_in.life  = 32'h0;
    tok_in.flag  = 1'b0;
    unique case (kind)
      KIND_LOOKUP: begin
        tok_in.op = KIND_LOOKUP;
      end
      KIND_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else if (bad_len) begin
          status_d = ST_BAD_LENGTH;
        end else begin
          tok_in.op   = KIND_INSERT;
          tok_in.addr = address_i & len_mask(prefix_length_i);
          tok_in.len  = prefix_length_i;
          tok_in.loc  = locator_i;
          tok_in.life = lifetime_i;
          tok_in.flag = 1'b1;
        end
      end
      KIND_DELETE: begin
        if (bad_len) begin
          status_d = ST_BAD_LENGTH;
        end else begin
          tok_in.op   = KIND_DELETE;
          tok_in.addr = address_i & len_mask(prefix_length_i);
          tok_in.len  = prefix_length_i;
        end
      end
      KIND_NONE: begin
      end
    endcase
  end

  assign tok_v[0] = accept;
  assign tok[0]   = tok_in;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lpm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .tok_v_i (tok_v[g]),
      .tok_i   (tok[g]),
      .nbr_i   (ent[g+1]),
      .tok_v_o (tok_v[g+1]),
      .tok_o   (tok[g+1]),
      .ent_o   (ent[g])
    );
  end

  assign done_o = tok_v[ENTRIES];
  assign busy_d = accept ? 1'b1 : (done_o ? 1'b0 : busy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
    end
  end

  assign busy_o           = busy_q && !done_o;
  assign status_o         = status_q;
  assign hit_o            = done_o && (tok[ENTRIES].op == KIND_LOOKUP) && tok[ENTRIES].flag;
  assign found_locator_o  = hit_o ? tok[ENTRIES].loc : 32'h0;
  assign found_lifetime_o = hit_o ? tok[ENTRIES].life : 32'h0;
  assign found_length_o   = hit_o ? tok[ENTRIES].len : 6'd0;

endmodule

[rtl/lpm_cell.sv]
// one table slot of the prefix map cache chain; processes the passing beat
// and hands it on to the older neighbor; depends on lpm_pkg
module lpm_cell import lpm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic tok_v_i,
  input  tok_t tok_i,
  input  ent_t nbr_i,
  output logic tok_v_o,
  output tok_t tok_o,
  output ent_t ent_o
);

  logic        ent_v_q, ent_v_d;
  logic [31:0] ent_pfx_q, ent_pfx_d;
  logic [5:0]  ent_len_q, ent_len_d;
  logic [31:0] ent_loc_q, ent_loc_d;
  logic [31:0] ent_life_q, ent_life_d;
  logic        tok_v_q;
  tok_t        tok_q, tok_d;
  logic        lk_take;
  logic        dl_hit;

  assign lk_take = ent_v_q && ((tok_i.addr & len_mask(ent_len_q)) == ent_pfx_q) &&
                   (!tok_i.flag || (ent_len_q > tok_i.len));
  assign dl_hit  = !tok_i.flag && ent_v_q && (ent_pfx_q == tok_i.addr) &&
                   (ent_len_q == tok_i.len);

  always_comb begin
    tok_d      = tok_i;
    ent_v_d    = ent_v_q;
    ent_pfx_d  = ent_pfx_q;
    ent_len_d  = ent_len_q;
    ent_loc_d  = ent_loc_q;
    ent_life_d = ent_life_q;
    if (tok_v_i) begin
      unique case (tok_i.op)
        KIND_LOOKUP: begin
          if (lk_take) begin
            tok_d.flag = 1'b1;
            tok_d.len  = ent_len_q;
            tok_d.loc  = ent_loc_q;
            tok_d.life = ent_life_q;
          end
        end
        KIND_INSERT: begin
          // swap the carried entry in, push the old one on
          if (tok_i.flag) begin
            ent_v_d    = 1'b1;
            ent_pfx_d  = tok_i.addr;
            ent_len_d  = tok_i.len;
            ent_loc_d  = tok_i.loc;
            ent_life_d = tok_i.life;
            tok_d.flag = ent_v_q;
            tok_d.addr = ent_pfx_q;
            tok_d.len  = ent_len_q;
            tok_d.loc  = ent_loc_q;
            tok_d.life = ent_life_q;
          end
        end
        KIND_DELETE: begin
          // close the gap by pulling the older neighbor up
          if (tok_i.flag || dl_hit) begin
            ent_v_d    = nbr_i.v;
            ent_pfx_d  = nbr_i.pfx;
            ent_len_d  = nbr_i.len;
            ent_loc_d  = nbr_i.loc;
            ent_life_d = nbr_i.life;
            tok_d.flag = 1'b1;
          end
        end
        KIND_NONE: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_v_q <= 1'b0;
      tok_v_q <= 1'b0;
    end else begin
      ent_v_q <= ent_v_d;
      tok_v_q <= tok_v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_pfx_q  <= ent_pfx_d;
    ent_len_q  <= ent_len_d;
    ent_loc_q  <= ent_loc_d;
    ent_life_q <= ent_life_d;
    tok_q      <= tok_d;
  end

  assign tok_v_o = tok_v_q;
  assign tok_o   = tok_q;
  assign ent_o   = '{v: ent_v_q, pfx: ent_pfx_q, len: ent_len_q,
                     loc: ent_loc_q, life: ent_life_q};

endmodule

[rtl/lpm_checker.sv]
// port-level checks for the prefix map cache core, bound to the top level
// depends on lpm_pkg
module lpm_checker import lpm_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic        hit_o,
  input logic [31:0] found_locator_o,
  input logic [31:0] found_lifetime_o,
  input logic [5:0]  found_length_o
);

  // an accepted beat keeps the block busy or finishes next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("accepted beat neither busy nor done");

  a_hit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o |-> (done_o && (status_o == ST_OK) && (found_length_o <= MaxLength)))
    else $error("hit outside a clean result");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |->
      ((found_locator_o == 32'h0) && (found_lifetime_o == 32'h0) &&
       (found_length_o == 6'd0)))
    else $error("miss result not zero");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o != ST_UNUSED))
    else $error("unused status code");

endmodule

bind lpm_prefix_map_cache_core lpm_checker u_lpm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .busy_o           (busy_o),
  .done_o           (done_o),
  .status_o         (status_o),
  .hit_o            (hit_o),
  .found_locator_o  (found_locator_o),
  .found_lifetime_o (found_lifetime_o),
  .found_length_o   (found_length_o)
);
